/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ils_pkg.sv */
package ils_pkg;

  localparam int POS_W = 7;
  localparam int LEN_W = 7;
  localparam int VAL_W = 32;

  localparam logic [VAL_W-1:0] READ_MISS = '1;

  typedef enum logic [2:0] {
    OP_READ = 3'd0,
    OP_HEAD = 3'd1,
    OP_TAIL = 3'd2,
    OP_AT   = 3'd3,
    OP_DEL  = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    read_valid;
    logic [LEN_W-1:0]        length;
    logic                    ignored;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic move;
    logic put;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic ins_ok;
    logic del_ok;
    logic ins_op;
    logic move_done;
    logic out_free;
  } status_t;

endpackage

/* rtl/ils_datapath.sv */
`include "assert_macros.svh"

module ils_datapath #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ils_pkg::in_word_t  in_word_i,
  input  ils_pkg::cmd_t      cmd_i,
  output ils_pkg::status_t   stat_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ils_pkg::out_word_t out_word_o
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW   = ils_pkg::POS_W;
  localparam int LW   = ils_pkg::LEN_W;
  localparam int CMPW = (CW > PW) ? CW : PW;

  logic [ils_pkg::VAL_W-1:0] mem [DEPTH];

  ils_pkg::in_word_t  item_q;
  ils_pkg::out_word_t out_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      rem_q;
  logic [AW-1:0]      cur_q;
  logic [AW-1:0]      wr_addr_q;
  logic               pend_q;
  logic               dir_up_q;
  logic [ils_pkg::VAL_W-1:0] rdata_q;
  logic               hit_q;
  logic               ign_q;
  logic               out_valid_q;

  logic [CMPW-1:0] pos_c, cnt_c, ipos_c, ins_n, del_n;
  logic is_read, is_ins, is_del, full, ins_ok, del_ok, rd_hit;
  logic move_rd, move_wr;

  always_comb begin
    pos_c   = CMPW'(item_q.position);
    cnt_c   = CMPW'(count_q);
    is_read = (item_q.opcode == ils_pkg::OP_READ);
    is_del  = (item_q.opcode == ils_pkg::OP_DEL);
    is_ins  = (item_q.opcode == ils_pkg::OP_HEAD) || (item_q.opcode == ils_pkg::OP_TAIL) ||
              (item_q.opcode == ils_pkg::OP_AT);
    case (item_q.opcode)
      ils_pkg::OP_HEAD: ipos_c = '0;
      ils_pkg::OP_TAIL: ipos_c = cnt_c;
      default:          ipos_c = pos_c;
    endcase
    full    = (count_q == CW'(DEPTH));
    ins_ok  = is_ins && !full && (ipos_c <= cnt_c);
    del_ok  = is_del && (pos_c < cnt_c);
    rd_hit  = is_read && (pos_c < cnt_c);
    ins_n   = cnt_c - ipos_c;
    del_n   = cnt_c - pos_c - CMPW'(1);
    move_rd = cmd_i.move && (rem_q != '0);
    move_wr = cmd_i.move && pend_q;
  end

  assign stat_o.ins_ok    = ins_ok;
  assign stat_o.del_ok    = del_ok;
  assign stat_o.ins_op    = is_ins;
  assign stat_o.move_done = (rem_q == '0) && !pend_q;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // list storage: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (move_wr) begin
      mem[wr_addr_q] <= rdata_q;
    end else if (cmd_i.put) begin
      mem[ipos_c[AW-1:0]] <= item_q.value;
    end
    if (move_rd) begin
      rdata_q <= mem[cur_q];
    end else if (cmd_i.eval && rd_hit) begin
      rdata_q <= mem[pos_c[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_word_i;
    end
    if (cmd_i.eval) begin
      hit_q <= rd_hit;
      ign_q <= (is_ins && !ins_ok) || (is_del && !del_ok);
    end
    if (cmd_i.finish) begin
      out_q.read_value <= hit_q ? rdata_q : ils_pkg::READ_MISS;
      out_q.read_valid <= hit_q;
      out_q.length     <= LW'(count_q);
      out_q.ignored    <= ign_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rem_q       <= '0;
      cur_q       <= '0;
      wr_addr_q   <= '0;
      pend_q      <= 1'b0;
      dir_up_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= move_rd;
      if (cmd_i.eval) begin
        if (ins_ok) begin
          cur_q    <= AW'(count_q - 1'b1);
          dir_up_q <= 1'b0;
          rem_q    <= CW'(ins_n);
        end else if (del_ok) begin
          cur_q    <= AW'(pos_c + CMPW'(1));
          dir_up_q <= 1'b1;
          rem_q    <= CW'(del_n);
          count_q  <= count_q - 1'b1;
        end else begin
          rem_q <= '0;
        end
      end else if (move_rd) begin
        rem_q <= rem_q - 1'b1;
        if (dir_up_q) begin
          cur_q     <= cur_q + 1'b1;
          wr_addr_q <= cur_q - 1'b1;
        end else begin
          cur_q     <= cur_q - 1'b1;
          wr_addr_q <= cur_q + 1'b1;
        end
      end
      if (cmd_i.put) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH), "count above depth")
  `ASSERT_IMPLIES(a_count_step, clk_i, rst_ni, count_q != $past(count_q),
    count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1,
    "count moved by more than one")
  `ASSERT_ALWAYS(a_one_write, clk_i, rst_ni, !(move_wr && cmd_i.put), "two memory writes")

endmodule

/* rtl/ils_ctrl.sv */
`include "assert_macros.svh"

module ils_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ils_pkg::status_t stat_i,
  output ils_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MOVE,
    S_PUT,
    S_DONE
  } state_e;

  state_e state_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.eval   = (state_q == S_EVAL);
    cmd_o.move   = (state_q == S_MOVE);
    cmd_o.put    = (state_q == S_PUT);
    cmd_o.finish = (state_q == S_DONE) && stat_i.out_free;
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EVAL;
        end
        S_EVAL: begin
          state_q <= (stat_i.ins_ok || stat_i.del_ok) ? S_MOVE : S_DONE;
        end
        S_MOVE: begin
          if (stat_i.move_done) state_q <= stat_i.ins_op ? S_PUT : S_DONE;
        end
        S_PUT: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (stat_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_finish_free, clk_i, rst_ni, cmd_o.finish, stat_i.out_free,
    "result word written into a busy output")
  `ASSERT_NEXT(a_put_done, clk_i, rst_ni, cmd_o.put, state_q == S_DONE,
    "insert write not followed by result")

endmodule

/* rtl/indexed_list_store.sv */
// Ordered list of up to DEPTH signed 32-bit words in a single-port-write, registered-read
// memory. One word is worked at a time. A read, an unknown opcode or a refused operation
// goes from evaluation straight to the result. An insert at position p moves the entries
// from p to the end up one place and then writes the new word at p; a delete at p moves
// the entries behind p down one place. The entries move one place per cycle through the
// memory's one read and one write port. The output register lets the next word be
// accepted while a result waits. No clearing pass follows reset.
module indexed_list_store #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ils_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ils_pkg::out_word_t out_word_o
);

  ils_pkg::cmd_t    cmd;
  ils_pkg::status_t stat;

  ils_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ils_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
